/* rtl/caf_pkg.sv */
// Shared types and constants for the flag-producing CPU arithmetic unit.
`default_nettype none

package caf_pkg;

   // Operation codes; codes 18 to 31 pass the operand and flags through.
   typedef enum logic [4:0] {
      ACT_ADD   = 5'd0,
      ACT_ADC   = 5'd1,
      ACT_SUB   = 5'd2,
      ACT_SBC   = 5'd3,
      ACT_AND   = 5'd4,
      ACT_XOR   = 5'd5,
      ACT_OR    = 5'd6,
      ACT_CP    = 5'd7,
      ACT_INC8  = 5'd8,
      ACT_DEC8  = 5'd9,
      ACT_DAA   = 5'd10,
      ACT_CPL   = 5'd11,
      ACT_SCF   = 5'd12,
      ACT_CCF   = 5'd13,
      ACT_ADD16 = 5'd14,
      ACT_ADDSP = 5'd15,
      ACT_INC16 = 5'd16,
      ACT_DEC16 = 5'd17
   } caf_action_type;

   // Decimal adjust corrections.
   localparam logic [8:0] DAA_LO_ADJ   = 9'h006;
   localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
   localparam logic [8:0] DAA_HI_LIMIT = 9'h0a0;
   localparam logic [7:0] DAA_SUB_LO   = 8'hfa;
   localparam logic [7:0] DAA_SUB_HI   = 8'ha0;
   localparam logic [3:0] BCD_MAX      = 4'h9;

   typedef struct packed {
      logic [4:0]  action;
      logic [15:0] first_operand;
      logic [15:0] second_operand;
      logic        zero_in;
      logic        subtract_in;
      logic        half_in;
      logic        carry_in;
   } caf_req_type;

   typedef struct packed {
      logic [15:0] result;
      logic        zero_out;
      logic        subtract_out;
      logic        half_out;
      logic        carry_out;
   } caf_rsp_type;

   // Adder results handed from the arithmetic stage to the select stage.
   typedef struct packed {
      logic [4:0]  action;
      logic [15:0] x16;
      logic [7:0]  b8;
      logic        zero_in;
      logic        subtract_in;
      logic        half_in;
      logic        carry_in;
      logic [8:0]  add9;
      logic        add_half;
      logic [8:0]  sub9;
      logic        sub_half;
      logic [16:0] sum17;
      logic        half16;
      logic [15:0] sp_sum;
      logic        sp_carry;
      logic        sp_half;
      logic [8:0]  daa_lo;
      logic [7:0]  daa_sub;
   } caf_sums_type;

endpackage

`default_nettype wire

/* rtl/caf_arith.sv */
// Arithmetic stage: the byte, word, stack-offset and decimal-adjust adders, results registered with a valid bit.
`default_nettype none

module caf_arith (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  valid_in,
   input  wire caf_pkg::caf_req_type  req_in,
   output logic                       valid_out,
   output caf_pkg::caf_sums_type      sums_out
);
   import caf_pkg::*;

   logic         valid_ff;
   caf_sums_type sums_ff;
   caf_sums_type sums_in;

   logic [7:0] a8;
   logic [7:0] b8;
   logic       ci_add;
   logic       ci_sub;
   logic [4:0] add_nib;
   logic [4:0] sub_nib;
   logic [12:0] nib16;
   logic [8:0] sp_lo;
   logic [4:0] sp_nib;

   always_comb begin
      a8     = req_in.first_operand[7:0];
      b8     = req_in.second_operand[7:0];
      ci_add = (req_in.action == ACT_ADC) && req_in.carry_in;
      ci_sub = (req_in.action == ACT_SBC) && req_in.carry_in;

      add_nib = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, ci_add};
      sub_nib = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, ci_sub};
      nib16   = {1'b0, req_in.first_operand[11:0]} + {1'b0, req_in.second_operand[11:0]};
      sp_lo   = {1'b0, a8} + {1'b0, b8};
      sp_nib  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};

      sums_in.action      = req_in.action;
      sums_in.x16         = req_in.first_operand;
      sums_in.b8          = b8;
      sums_in.zero_in     = req_in.zero_in;
      sums_in.subtract_in = req_in.subtract_in;
      sums_in.half_in     = req_in.half_in;
      sums_in.carry_in    = req_in.carry_in;
      sums_in.add9        = {1'b0, a8} + {1'b0, b8} + {8'd0, ci_add};
      sums_in.add_half    = add_nib[4];
      // Bit 8 of the nine-bit difference is the borrow.
      sums_in.sub9        = {1'b0, a8} - {1'b0, b8} - {8'd0, ci_sub};
      sums_in.sub_half    = sub_nib[4];
      sums_in.sum17       = {1'b0, req_in.first_operand} + {1'b0, req_in.second_operand};
      sums_in.half16      = nib16[12];
      sums_in.sp_sum      = req_in.first_operand + {{8{b8[7]}}, b8};
      sums_in.sp_carry    = sp_lo[8];
      sums_in.sp_half     = sp_nib[4];
      sums_in.daa_lo      = {1'b0, a8} +
                            (((a8[3:0] > BCD_MAX) || req_in.half_in) ? DAA_LO_ADJ : 9'd0);
      sums_in.daa_sub     = a8 + (req_in.half_in ? DAA_SUB_LO : 8'd0)
                               + (req_in.carry_in ? DAA_SUB_HI : 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sums_ff <= sums_in;
   end

   assign valid_out = valid_ff;
   assign sums_out  = sums_ff;

endmodule

`default_nettype wire

/* rtl/cpu_alu_with_flags.sv */
// Top level of the flag-producing 8/16-bit CPU arithmetic unit.
`default_nettype none

// A request is taken at each rising edge where start is high and busy is low;
// busy is high only while reset is asserted, so one request may enter every
// cycle. Each request gives exactly one response: rsp_valid pulses for one
// cycle, once the request has passed the capture, adder and select
// registers, with the new value and the Z, N, H and C flags in rsp_data.
// Responses leave in request order and cannot be held off; the receiver
// must take each one in the cycle it shows. The three-stage pipeline
// (capture, adders, select and flags) takes one request per clock. The
// unit keeps no state between requests.

module cpu_alu_with_flags (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire caf_pkg::caf_req_type  req_data,
   output logic                       rsp_valid,
   output caf_pkg::caf_rsp_type       rsp_data
);
   import caf_pkg::*;

   // Stage 1: capture the request.
   logic        req_valid_ff;
   caf_req_type req_ff;

   // Stage 2: adder results.
   logic         sums_valid;
   caf_sums_type sums;

   // Stage 3: selected result and flags.
   logic        rsp_valid_ff;
   caf_rsp_type rsp_ff;
   caf_rsp_type rsp_in;

   logic accept;

   // Hold off requests only during reset; the pipeline never stalls.
   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   caf_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (req_valid_ff),
      .req_in    (req_ff),
      .valid_out (sums_valid),
      .sums_out  (sums)
   );

   // Select the value and flags for the operation; 8-bit results sit in the
   // low byte with the upper byte cleared.
   logic [7:0] a8;
   logic [7:0] res8;
   logic       daa_hi;

   always_comb begin
      a8     = sums.x16[7:0];
      res8   = 8'd0;
      daa_hi = (sums.daa_lo >= DAA_HI_LIMIT) || sums.carry_in;

      // Default: pass the operand and all flags through.
      rsp_in.result       = sums.x16;
      rsp_in.zero_out     = sums.zero_in;
      rsp_in.subtract_out = sums.subtract_in;
      rsp_in.half_out     = sums.half_in;
      rsp_in.carry_out    = sums.carry_in;

      unique case (sums.action)
         ACT_ADD, ACT_ADC: begin
            res8                = sums.add9[7:0];
            rsp_in.result       = {8'd0, res8};
            rsp_in.zero_out     = (res8 == 8'd0);
            rsp_in.subtract_out = 1'b0;
            rsp_in.half_out     = sums.add_half;
            rsp_in.carry_out    = sums.add9[8];
         end
         ACT_SUB, ACT_SBC, ACT_CP: begin
            // Compare keeps the accumulator but flags the difference.
            res8                = sums.sub9[7:0];
            rsp_in.result       = {8'd0, (sums.action == ACT_CP) ? a8 : res8};
            rsp_in.zero_out     = (res8 == 8'd0);
            rsp_in.subtract_out = 1'b1;
            rsp_in.half_out     = sums.sub_half;
            rsp_in.carry_out    = sums.sub9[8];
         end
         ACT_AND: begin
            res8                = a8 & sums.b8;
            rsp_in.result       = {8'd0, res8};
            rsp_in.zero_out     = (res8 == 8'd0);
            rsp_in.subtract_out = 1'b0;
            rsp_in.half_out     = 1'b1;
            rsp_in.carry_out    = 1'b0;
         end
         ACT_XOR, ACT_OR: begin
            res8                = (sums.action == ACT_XOR) ? (a8 ^ sums.b8) : (a8 | sums.b8);
            rsp_in.result       = {8'd0, res8};
            rsp_in.zero_out     = (res8 == 8'd0);
            rsp_in.subtract_out = 1'b0;
            rsp_in.half_out     = 1'b0;
            rsp_in.carry_out    = 1'b0;
         end
         ACT_INC8: begin
            res8                = a8 + 8'd1;
            rsp_in.result       = {8'd0, res8};
            rsp_in.zero_out     = (res8 == 8'd0);
            rsp_in.subtract_out = 1'b0;
            rsp_in.half_out     = (a8[3:0] == 4'hf);
         end
         ACT_DEC8: begin
            res8                = a8 - 8'd1;
            rsp_in.result       = {8'd0, res8};
            rsp_in.zero_out     = (res8 == 8'd0);
            rsp_in.subtract_out = 1'b1;
            rsp_in.half_out     = (a8[3:0] == 4'h0);
         end
         ACT_DAA: begin
            // After a subtract the correction was fully formed in stage 2 and
            // carry is kept; after an add finish the high-digit correction here.
            if (sums.subtract_in) begin
               res8 = sums.daa_sub;
            end else begin
               res8             = sums.daa_lo[7:0] + (daa_hi ? DAA_HI_ADJ : 8'd0);
               rsp_in.carry_out = daa_hi;
            end
            rsp_in.result   = {8'd0, res8};
            rsp_in.zero_out = (res8 == 8'd0);
            rsp_in.half_out = 1'b0;
         end
         ACT_CPL: begin
            rsp_in.result       = {8'd0, ~a8};
            rsp_in.subtract_out = 1'b1;
            rsp_in.half_out     = 1'b1;
         end
         ACT_SCF, ACT_CCF: begin
            rsp_in.result       = {8'd0, a8};
            rsp_in.subtract_out = 1'b0;
            rsp_in.half_out     = 1'b0;
            rsp_in.carry_out    = (sums.action == ACT_SCF) ? 1'b1 : !sums.carry_in;
         end
         ACT_ADD16: begin
            rsp_in.result       = sums.sum17[15:0];
            rsp_in.subtract_out = 1'b0;
            rsp_in.half_out     = sums.half16;
            rsp_in.carry_out    = sums.sum17[16];
         end
         ACT_ADDSP: begin
            // Flags come from the unsigned low-byte add, not the signed sum.
            rsp_in.result       = sums.sp_sum;
            rsp_in.zero_out     = 1'b0;
            rsp_in.subtract_out = 1'b0;
            rsp_in.half_out     = sums.sp_half;
            rsp_in.carry_out    = sums.sp_carry;
         end
         ACT_INC16: begin
            rsp_in.result = sums.x16 + 16'd1;
         end
         ACT_DEC16: begin
            rsp_in.result = sums.x16 - 16'd1;
         end
         default: begin
            rsp_in.result = sums.x16;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sums_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Every accepted request gives a matching response.
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("accepted request produced no response");

   // No response appears without an earlier accepted request.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("response without a matching request");

   // A logical and always sets half-carry and clears carry.
   a_and_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(req_data.action, 3) == ACT_AND)
         |-> rsp_data.half_out && !rsp_data.carry_out && !rsp_data.subtract_out)
      else $error("and produced wrong flags");

endmodule

`default_nettype wire
